// ===== rtl/spectrum_window_count_cost_top_assert.svh =====
// Assertion macros for the window count and cost RTL, used by swcc_cost.
// Each property is clocked on the rising edge and disabled while reset is high.
`ifndef SPECTRUM_WINDOW_COUNT_COST_TOP_ASSERT_SVH
`define SPECTRUM_WINDOW_COUNT_COST_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication
`define SWCC_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("swcc assertion failed");

// Next-cycle implication
`define SWCC_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("swcc assertion failed");

`else

`define SWCC_ASSERT_IMP(lbl, clk, rst, ante, cons)
`define SWCC_ASSERT_NXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ===== rtl/swcc_pkg.sv =====
`default_nettype none

package swcc_pkg;

   // Slot count and field widths
   localparam int MAX_SLOTS = 64;
   localparam int FREE_W    = 64;
   localparam int WIDTH_W   = 7;
   localparam int HOP_W     = 8;
   localparam int ACTIVE_W  = 7;
   localparam int WEIGHT_W  = 25;
   localparam int CNT_W     = 7;
   localparam int COST_W    = 25;
   localparam int ROUTE_W   = 33;

   // 1.0 in Q.24
   localparam logic [COST_W-1:0] ONE_Q24 = COST_W'(1 << 24);

   // Register values after reset: all slots active, weight 0.9999
   localparam logic [ACTIVE_W-1:0] ACTIVE_RESET = ACTIVE_W'(64);
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = WEIGHT_W'(16775539);

   // Popcount tree
   localparam int GRP_SIZE  = 8;
   localparam int GRP_NUM   = (MAX_SLOTS + GRP_SIZE - 1) / GRP_SIZE;
   localparam int GRP_CNT_W = $clog2(GRP_SIZE + 1);

   // Rounded divide by (count+1): numerator 2*N+den, divisor 2*den
   localparam int NUM_W       = COST_W + 1;
   localparam int D2_W        = CNT_W + 1;
   localparam int RECIP_W     = 27;
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_NUM   = 1 << (RECIP_SHIFT - 1);
   localparam int PROD_W      = NUM_W + RECIP_W;
   localparam int QEST_W      = PROD_W - RECIP_SHIFT;
   localparam int RECIP_DEPTH = 66;

   // floor(2^27 / (2*den)), indexed by den = count+1
   localparam logic [RECIP_W-1:0] RECIP_TBL [RECIP_DEPTH] = '{
      RECIP_W'(0),              RECIP_W'(RECIP_NUM / 1),
      RECIP_W'(RECIP_NUM / 2),  RECIP_W'(RECIP_NUM / 3),
      RECIP_W'(RECIP_NUM / 4),  RECIP_W'(RECIP_NUM / 5),
      RECIP_W'(RECIP_NUM / 6),  RECIP_W'(RECIP_NUM / 7),
      RECIP_W'(RECIP_NUM / 8),  RECIP_W'(RECIP_NUM / 9),
      RECIP_W'(RECIP_NUM / 10), RECIP_W'(RECIP_NUM / 11),
      RECIP_W'(RECIP_NUM / 12), RECIP_W'(RECIP_NUM / 13),
      RECIP_W'(RECIP_NUM / 14), RECIP_W'(RECIP_NUM / 15),
      RECIP_W'(RECIP_NUM / 16), RECIP_W'(RECIP_NUM / 17),
      RECIP_W'(RECIP_NUM / 18), RECIP_W'(RECIP_NUM / 19),
      RECIP_W'(RECIP_NUM / 20), RECIP_W'(RECIP_NUM / 21),
      RECIP_W'(RECIP_NUM / 22), RECIP_W'(RECIP_NUM / 23),
      RECIP_W'(RECIP_NUM / 24), RECIP_W'(RECIP_NUM / 25),
      RECIP_W'(RECIP_NUM / 26), RECIP_W'(RECIP_NUM / 27),
      RECIP_W'(RECIP_NUM / 28), RECIP_W'(RECIP_NUM / 29),
      RECIP_W'(RECIP_NUM / 30), RECIP_W'(RECIP_NUM / 31),
      RECIP_W'(RECIP_NUM / 32), RECIP_W'(RECIP_NUM / 33),
      RECIP_W'(RECIP_NUM / 34), RECIP_W'(RECIP_NUM / 35),
      RECIP_W'(RECIP_NUM / 36), RECIP_W'(RECIP_NUM / 37),
      RECIP_W'(RECIP_NUM / 38), RECIP_W'(RECIP_NUM / 39),
      RECIP_W'(RECIP_NUM / 40), RECIP_W'(RECIP_NUM / 41),
      RECIP_W'(RECIP_NUM / 42), RECIP_W'(RECIP_NUM / 43),
      RECIP_W'(RECIP_NUM / 44), RECIP_W'(RECIP_NUM / 45),
      RECIP_W'(RECIP_NUM / 46), RECIP_W'(RECIP_NUM / 47),
      RECIP_W'(RECIP_NUM / 48), RECIP_W'(RECIP_NUM / 49),
      RECIP_W'(RECIP_NUM / 50), RECIP_W'(RECIP_NUM / 51),
      RECIP_W'(RECIP_NUM / 52), RECIP_W'(RECIP_NUM / 53),
      RECIP_W'(RECIP_NUM / 54), RECIP_W'(RECIP_NUM / 55),
      RECIP_W'(RECIP_NUM / 56), RECIP_W'(RECIP_NUM / 57),
      RECIP_W'(RECIP_NUM / 58), RECIP_W'(RECIP_NUM / 59),
      RECIP_W'(RECIP_NUM / 60), RECIP_W'(RECIP_NUM / 61),
      RECIP_W'(RECIP_NUM / 62), RECIP_W'(RECIP_NUM / 63),
      RECIP_W'(RECIP_NUM / 64), RECIP_W'(RECIP_NUM / 65)
   };

   // Register indexes of the csr port
   typedef enum logic [0:0] {
      CSR_ACTIVE_SLOTS = 1'b0,
      CSR_ROUTE_WEIGHT = 1'b1
   } csr_index_type;

   // Lane stage -> merge
   typedef struct packed {
      logic [MAX_SLOTS-1:0] win;
      logic [HOP_W-1:0]     hops;
   } lane_out_type;

   // Merge -> cost
   typedef struct packed {
      logic [CNT_W-1:0] cnt;
      logic [HOP_W-1:0] hops;
   } count_out_type;

   // Cost -> result port
   typedef struct packed {
      logic [CNT_W-1:0]   form_count;
      logic [COST_W-1:0]  link_cost;
      logic [ROUTE_W-1:0] routing_cost;
      logic               no_fit;
   } result_type;

endpackage

`default_nettype wire

// ===== rtl/swcc_lanes.sv =====
`default_nettype none

module swcc_lanes (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire logic [swcc_pkg::FREE_W-1:0]    free_slots,
   input  wire logic [swcc_pkg::WIDTH_W-1:0]   request_width,
   input  wire logic [swcc_pkg::HOP_W-1:0]     hop_count,
   input  wire logic [swcc_pkg::ACTIVE_W-1:0]  active_slots,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output swcc_pkg::lane_out_type              out_data
);
   import swcc_pkg::*;

   logic [ACTIVE_W-1:0]  act_sat;
   logic [MAX_SLOTS-1:0] busy;
   logic [MAX_SLOTS-1:0] wmask;
   logic [MAX_SLOTS-1:0] fit;
   logic                 load;
   logic                 valid_ff;
   lane_out_type         data_in;
   lane_out_type         data_ff;

   // Busy map over the active slots, and the request's window mask
   always_comb begin
      act_sat = (active_slots > ACTIVE_W'(MAX_SLOTS)) ? ACTIVE_W'(MAX_SLOTS) : active_slots;
      for (int j = 0; j < MAX_SLOTS; j++) begin
         busy[j]  = ~(free_slots[j] && (ACTIVE_W'(j) < act_sat));
         wmask[j] = (WIDTH_W'(j) < request_width);
      end
   end

   // One lane per start position: window must stay in range and be all free
   for (genvar i = 0; i < MAX_SLOTS; i++) begin : g_lane
      assign fit[i] = (request_width != '0)
                   && (request_width <= WIDTH_W'(MAX_SLOTS - i))
                   && ((busy[MAX_SLOTS-1:i] & wmask[MAX_SLOTS-1-i:0]) == '0);
   end

   assign data_in.win  = fit;
   assign data_in.hops = hop_count;

   // Stage register
   assign load     = !valid_ff || out_ready;
   assign in_ready = load;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (load) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (load && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

`default_nettype wire

// ===== rtl/swcc_merge.sv =====
`default_nettype none

module swcc_merge (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     in_valid,
   output logic                          in_ready,
   input  wire swcc_pkg::lane_out_type   in_data,
   output logic                          out_valid,
   input  wire logic                     out_ready,
   output swcc_pkg::count_out_type       out_data
);
   import swcc_pkg::*;

   logic [GRP_CNT_W-1:0] grp_in [GRP_NUM];
   logic [GRP_CNT_W-1:0] grp_ff [GRP_NUM];
   logic [HOP_W-1:0]     hops_ff;
   logic                 va_ff;
   logic                 vb_ff;
   logic                 load_a;
   logic                 load_b;
   count_out_type        cnt_in;
   count_out_type        cnt_ff;

   assign load_b   = !vb_ff || out_ready;
   assign load_a   = !va_ff || load_b;
   assign in_ready = load_a;

   // First level: popcount of each group of lanes
   always_comb begin
      for (int g = 0; g < GRP_NUM; g++) begin
         grp_in[g] = '0;
         for (int j = 0; j < GRP_SIZE; j++) begin
            if (g * GRP_SIZE + j < MAX_SLOTS) begin
               grp_in[g] = grp_in[g] + GRP_CNT_W'(in_data.win[g * GRP_SIZE + j]);
            end
         end
      end
   end

   // Second level: sum of group counts
   always_comb begin
      cnt_in.cnt  = '0;
      cnt_in.hops = hops_ff;
      for (int g = 0; g < GRP_NUM; g++) begin
         cnt_in.cnt = cnt_in.cnt + CNT_W'(grp_ff[g]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
      end else begin
         if (load_a) begin
            va_ff <= in_valid;
         end
         if (load_b) begin
            vb_ff <= va_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_a && in_valid) begin
         grp_ff  <= grp_in;
         hops_ff <= in_data.hops;
      end
      if (load_b && va_ff) begin
         cnt_ff <= cnt_in;
      end
   end

   assign out_valid = vb_ff;
   assign out_data  = cnt_ff;

endmodule

`default_nettype wire

// ===== rtl/swcc_cost.sv =====
`default_nettype none
`include "spectrum_window_count_cost_top_assert.svh"

module swcc_cost (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   output logic                                in_ready,
   input  wire swcc_pkg::count_out_type        in_data,
   input  wire logic [swcc_pkg::WEIGHT_W-1:0]  route_weight,
   output logic                                out_valid,
   input  wire logic                           out_ready,
   output swcc_pkg::result_type                out_data
);
   import swcc_pkg::*;

   // Estimate stage signals
   logic [WEIGHT_W-1:0] w_sat;
   logic [CNT_W-1:0]    den;
   logic [COST_W-1:0]   nr;
   logic [NUM_W-1:0]    xr_in;
   logic [NUM_W-1:0]    xl_in;
   logic [RECIP_W-1:0]  rc;
   logic [PROD_W-1:0]   prod_r;
   logic [PROD_W-1:0]   prod_l;
   logic [ROUTE_W-1:0]  wh_in;

   logic                v4_ff;
   logic [NUM_W-1:0]    xr_ff;
   logic [NUM_W-1:0]    xl_ff;
   logic [QEST_W-1:0]   qr_est_ff;
   logic [QEST_W-1:0]   ql_est_ff;
   logic [D2_W-1:0]     d2_ff;
   logic [ROUTE_W-1:0]  wh4_ff;
   logic [CNT_W-1:0]    cnt4_ff;

   // Correction stage signals
   logic [QEST_W+D2_W-1:0] back_r;
   logic [QEST_W+D2_W-1:0] back_l;
   logic [NUM_W-1:0]       rem_r;
   logic [NUM_W-1:0]       rem_l;
   logic [COST_W-1:0]      qr_in;
   logic [COST_W-1:0]      ql_in;

   logic                v5_ff;
   logic [COST_W-1:0]   qr_ff;
   logic [COST_W-1:0]   ql_ff;
   logic [ROUTE_W-1:0]  wh5_ff;
   logic [CNT_W-1:0]    cnt5_ff;

   // Output stage
   result_type          res_in;
   result_type          res_ff;
   logic                v6_ff;

   logic                load4;
   logic                load5;
   logic                load6;

   assign load6    = !v6_ff || out_ready;
   assign load5    = !v5_ff || load6;
   assign load4    = !v4_ff || load5;
   assign in_ready = load4;

   // Reciprocal estimate of round(N/den) for route and link, weighted hops
   always_comb begin
      w_sat  = (route_weight > WEIGHT_W'(ONE_Q24)) ? WEIGHT_W'(ONE_Q24) : route_weight;
      den    = in_data.cnt + CNT_W'(1);
      nr     = ONE_Q24 - COST_W'(w_sat);
      xr_in  = {nr, 1'b0} + NUM_W'(den);
      xl_in  = {ONE_Q24, 1'b0} + NUM_W'(den);
      rc     = RECIP_TBL[den];
      prod_r = PROD_W'(xr_in) * PROD_W'(rc);
      prod_l = PROD_W'(xl_in) * PROD_W'(rc);
      wh_in  = ROUTE_W'(w_sat) * ROUTE_W'(in_data.hops);
   end

   // Estimate is exact or one low: fix with one compare and add
   always_comb begin
      back_r = qr_est_ff * d2_ff;
      back_l = ql_est_ff * d2_ff;
      rem_r  = xr_ff - back_r[NUM_W-1:0];
      rem_l  = xl_ff - back_l[NUM_W-1:0];
      qr_in  = (rem_r >= NUM_W'(d2_ff)) ? COST_W'(qr_est_ff + QEST_W'(1))
                                        : COST_W'(qr_est_ff);
      ql_in  = (rem_l >= NUM_W'(d2_ff)) ? COST_W'(ql_est_ff + QEST_W'(1))
                                        : COST_W'(ql_est_ff);
   end

   // Final result, saturated when nothing fits
   always_comb begin
      res_in.form_count   = cnt5_ff;
      res_in.link_cost    = ql_ff;
      res_in.no_fit       = (cnt5_ff == '0);
      res_in.routing_cost = (cnt5_ff == '0) ? '1 : (wh5_ff + ROUTE_W'(qr_ff));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         if (load4) begin
            v4_ff <= in_valid;
         end
         if (load5) begin
            v5_ff <= v4_ff;
         end
         if (load6) begin
            v6_ff <= v5_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load4 && in_valid) begin
         xr_ff     <= xr_in;
         xl_ff     <= xl_in;
         qr_est_ff <= prod_r[PROD_W-1:RECIP_SHIFT];
         ql_est_ff <= prod_l[PROD_W-1:RECIP_SHIFT];
         d2_ff     <= {den, 1'b0};
         wh4_ff    <= wh_in;
         cnt4_ff   <= in_data.cnt;
      end
      if (load5 && v4_ff) begin
         qr_ff   <= qr_in;
         ql_ff   <= ql_in;
         wh5_ff  <= wh4_ff;
         cnt5_ff <= cnt4_ff;
      end
      if (load6 && v5_ff) begin
         res_ff <= res_in;
      end
   end

   assign out_valid = v6_ff;
   assign out_data  = res_ff;

   // Reciprocal estimate is never more than one below the quotient
   `SWCC_ASSERT_IMP(a_route_est_close, clock, reset, v4_ff, rem_r < (NUM_W'(d2_ff) + NUM_W'(d2_ff)))
   `SWCC_ASSERT_IMP(a_link_est_close, clock, reset, v4_ff, rem_l < (NUM_W'(d2_ff) + NUM_W'(d2_ff)))
   // Route share of 1/den never exceeds the full link cost
   `SWCC_ASSERT_IMP(a_route_le_link, clock, reset, v5_ff, qr_ff <= ql_ff)
   // A fitting item never yields the saturated routing cost
   `SWCC_ASSERT_IMP(a_fit_not_sat, clock, reset, v6_ff && !res_ff.no_fit, res_ff.routing_cost != '1)
   // A held result stays put while the receiver stalls
   `SWCC_ASSERT_NXT(a_hold_result, clock, reset, v6_ff && !out_ready, v6_ff && $stable(res_ff))

endmodule

`default_nettype wire

// ===== rtl/spectrum_window_count_cost_top.sv =====
// Contiguous free-slot window counter with link and routing cost.
// Request channel (req_valid / req_stall): a slot bitmap, a request width and a
// hop count; a transaction is taken on a clock edge with req_valid high and
// req_stall low. Result channel (rsp_valid / rsp_stall): window count, link
// cost 1/(count+1), routing cost weight*hops + (1-weight)/(count+1), both Q.24
// rounded to nearest, and a no-fit flag with routing cost all ones.
// CSR channel (csr_valid / csr_ready, ready always high): index 0 active slot
// count, index 1 hop weight; write only while no transaction is in flight.
// Throughput: one transaction per cycle while req_stall is low; 64 window
// lanes in parallel, a two-level popcount merge, then a reciprocal-multiply
// divide with a one-step correction, each stage registered.
// Reset clears every stage valid and loads 64 active slots and weight 0.9999.
// When rsp_stall holds a result, bubbles in the pipe still fill; req_stall
// rises only once every stage holds a transaction.
`default_nettype none

module spectrum_window_count_cost_top (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // Request channel
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [swcc_pkg::FREE_W-1:0]     req_free_slots,
   input  wire logic [swcc_pkg::WIDTH_W-1:0]    req_request_width,
   input  wire logic [swcc_pkg::HOP_W-1:0]      req_hop_count,
   // Result channel
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic [swcc_pkg::CNT_W-1:0]           rsp_form_count,
   output logic [swcc_pkg::COST_W-1:0]          rsp_link_cost,
   output logic [swcc_pkg::ROUTE_W-1:0]         rsp_routing_cost,
   output logic                                 rsp_no_fit,
   // CSR write channel
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire swcc_pkg::csr_index_type         csr_index,
   input  wire logic [swcc_pkg::WEIGHT_W-1:0]   csr_wdata
);
   import swcc_pkg::*;

   logic [ACTIVE_W-1:0] active_ff;
   logic [WEIGHT_W-1:0] weight_ff;

   logic                lanes_ready;
   logic                lanes_valid;
   lane_out_type        lanes_data;
   logic                merge_ready;
   logic                merge_valid;
   count_out_type       merge_data;
   logic                cost_ready;
   result_type          cost_data;

   // Configuration registers
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACTIVE_RESET;
         weight_ff <= WEIGHT_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_ACTIVE_SLOTS: begin
               active_ff <= csr_wdata[ACTIVE_W-1:0];
            end
            CSR_ROUTE_WEIGHT: begin
               weight_ff <= csr_wdata;
            end
            default: begin
            end
         endcase
      end
   end

   // Window lanes
   swcc_lanes u_lanes (
      .clock         (clock),
      .reset         (reset),
      .in_valid      (req_valid),
      .in_ready      (lanes_ready),
      .free_slots    (req_free_slots),
      .request_width (req_request_width),
      .hop_count     (req_hop_count),
      .active_slots  (active_ff),
      .out_valid     (lanes_valid),
      .out_ready     (merge_ready),
      .out_data      (lanes_data)
   );

   // Lane merge (popcount)
   swcc_merge u_merge (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lanes_valid),
      .in_ready  (merge_ready),
      .in_data   (lanes_data),
      .out_valid (merge_valid),
      .out_ready (cost_ready),
      .out_data  (merge_data)
   );

   // Costs and output register
   swcc_cost u_cost (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (merge_valid),
      .in_ready     (cost_ready),
      .in_data      (merge_data),
      .route_weight (weight_ff),
      .out_valid    (rsp_valid),
      .out_ready    (!rsp_stall),
      .out_data     (cost_data)
   );

   assign req_stall        = !lanes_ready;
   assign rsp_form_count   = cost_data.form_count;
   assign rsp_link_cost    = cost_data.link_cost;
   assign rsp_routing_cost = cost_data.routing_cost;
   assign rsp_no_fit       = cost_data.no_fit;

endmodule

`default_nettype wire

// ===== dv/tb_spectrum_window_count_cost_top.sv =====
`timescale 1ns / 100ps

module tb_spectrum_window_count_cost_top;
   import swcc_pkg::*;

   localparam int PIPE_LATENCY = 5;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int REPORT_LIMIT = 40;

   // Expected window counts and costs, one entry per accepted request
   class slot_cost_scoreboard;
      localparam longint unsigned UNITY_Q24 = 64'd1 << 24;
      localparam longint unsigned ROUTE_SAT = (64'd1 << ROUTE_W) - 1;

      result_type           pending_costs[$];
      int                   errors;
      logic [ACTIVE_W-1:0]  active_slots;
      logic [WEIGHT_W-1:0]  hop_weight;

      function new();
         errors       = 0;
         active_slots = ACTIVE_W'(MAX_SLOTS);
         hop_weight   = WEIGHT_RESET;
      endfunction

      function void set_register(csr_index_type idx, logic [WEIGHT_W-1:0] data);
         case (idx)
            CSR_ACTIVE_SLOTS: active_slots = data[ACTIVE_W-1:0];
            CSR_ROUTE_WEIGHT: hop_weight = data;
            default: ;
         endcase
      endfunction

      function int pending();
         return pending_costs.size();
      endfunction

      // Count fitting windows, then derive both Q.24 costs
      function result_type predict_costs(logic [FREE_W-1:0] free_slots,
                                         logic [WIDTH_W-1:0] req_width,
                                         logic [HOP_W-1:0] hops);
         int                   act;
         int                   n;
         logic [FREE_W-1:0]    usable;
         logic [FREE_W-1:0]    fits;
         longint unsigned      den;
         longint unsigned      w;
         longint unsigned      route;
         result_type           r;
         act = (int'(active_slots) > MAX_SLOTS) ? MAX_SLOTS : int'(active_slots);
         n = 0;
         if (req_width != 0 && act != 0 && int'(req_width) <= act) begin
            usable = (act >= 64) ? '1 : ((64'd1 << act) - 64'd1);
            usable &= free_slots;
            fits = usable;
            for (int i = 1; i < int'(req_width); i++)
               fits &= usable >> i;
            n = $countones(fits);
         end
         den = longint'(n) + 1;
         // weight above 1.0 saturates
         w = (longint'(hop_weight) > UNITY_Q24) ? UNITY_Q24 : longint'(hop_weight);
         if (n == 0)
            route = ROUTE_SAT;
         else
            route = w * longint'(hops) + (2 * (UNITY_Q24 - w) + den) / (2 * den);
         r.form_count   = CNT_W'(n);
         r.link_cost    = COST_W'((2 * UNITY_Q24 + den) / (2 * den));
         r.routing_cost = ROUTE_W'(route);
         r.no_fit       = (n == 0);
         return r;
      endfunction

      function void note_request(logic [FREE_W-1:0] free_slots,
                                 logic [WIDTH_W-1:0] req_width,
                                 logic [HOP_W-1:0] hops);
         pending_costs.insert(pending_costs.size(),
                              predict_costs(free_slots, req_width, hops));
      endfunction

      task report(string what, longint unsigned got, longint unsigned want);
         if (errors < REPORT_LIMIT)
            $display("tb: mismatch %s got %0h want %0h", what, got, want);
         errors++;
      endtask

      task check_result(result_type got);
         result_type want;
         if (pending_costs.size() == 0) begin
            report("unexpected transaction", got.form_count, 0);
            return;
         end
         want = pending_costs.pop_front();
         if (got.form_count !== want.form_count)
            report("form_count", got.form_count, want.form_count);
         if (got.link_cost !== want.link_cost)
            report("link_cost", got.link_cost, want.link_cost);
         if (got.routing_cost !== want.routing_cost)
            report("routing_cost", got.routing_cost, want.routing_cost);
         if (got.no_fit !== want.no_fit)
            report("no_fit", got.no_fit, want.no_fit);
      endtask
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [FREE_W-1:0]     req_free_slots = '0;
   logic [WIDTH_W-1:0]    req_request_width = '0;
   logic [HOP_W-1:0]      req_hop_count = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CNT_W-1:0]      rsp_form_count;
   logic [COST_W-1:0]     rsp_link_cost;
   logic [ROUTE_W-1:0]    rsp_routing_cost;
   logic                  rsp_no_fit;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_ACTIVE_SLOTS;
   logic [WEIGHT_W-1:0]   csr_wdata = '0;

   slot_cost_scoreboard   sb = new();
   bit                    calm = 1'b0;   // no idling on either side
   int                    cycles = 0;

   spectrum_window_count_cost_top u_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_free_slots    (req_free_slots),
      .req_request_width (req_request_width),
      .req_hop_count     (req_hop_count),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_form_count    (rsp_form_count),
      .rsp_link_cost     (rsp_link_cost),
      .rsp_routing_cost  (rsp_routing_cost),
      .rsp_no_fit        (rsp_no_fit),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always #6 clock = ~clock;

   // Watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // Accepted request transactions feed the predictor
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_request(req_free_slots, req_request_width, req_hop_count);
   end

   // Accepted result transactions are checked in order
   always @(posedge clock) begin
      result_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.form_count   = rsp_form_count;
         got.link_cost    = rsp_link_cost;
         got.routing_cost = rsp_routing_cost;
         got.no_fit       = rsp_no_fit;
         sb.check_result(got);
      end
   end

   // Result side back-pressure in random bursts
   initial begin
      forever begin
         @(negedge clock);
         if (calm || reset) begin
            rsp_stall = 1'b0;
         end else if ($urandom_range(3) == 0) begin
            rsp_stall = 1'b1;
            repeat ($urandom_range(10, 1) - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
         end
      end
   end

   // Called right after a falling edge; returns right after one
   task automatic send_request(logic [FREE_W-1:0] free_slots,
                               logic [WIDTH_W-1:0] req_width,
                               logic [HOP_W-1:0] hops);
      int gap;
      if (!calm && $urandom_range(3) == 0) begin
         gap = $urandom_range(10, 1);
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid         = 1'b1;
      req_free_slots    = free_slots;
      req_request_width = req_width;
      req_hop_count     = hops;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   // Both registers, pipe empty
   task automatic configure(logic [WEIGHT_W-1:0] active, logic [WEIGHT_W-1:0] weight);
      csr_valid = 1'b1;
      csr_index = CSR_ACTIVE_SLOTS;
      csr_wdata = active;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_ACTIVE_SLOTS, active);
      @(negedge clock);
      csr_index = CSR_ROUTE_WEIGHT;
      csr_wdata = weight;
      do @(posedge clock); while (!csr_ready);
      sb.set_register(CSR_ROUTE_WEIGHT, weight);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic drain();
      while (sb.pending() != 0) @(negedge clock);
   endtask

   function automatic logic [FREE_W-1:0] pick_free_slots();
      logic [FREE_W-1:0] v;
      int                start;
      case ($urandom_range(5))
         0: v = {$urandom, $urandom};
         1: v = {$urandom, $urandom} | {$urandom, $urandom} | {$urandom, $urandom};
         2: v = {$urandom, $urandom} & {$urandom, $urandom};
         3: v = ~((64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63)));
         4: begin
            // a few contiguous free runs
            v = '0;
            repeat ($urandom_range(4, 1)) begin
               start = $urandom_range(63);
               v |= ((64'd1 << $urandom_range(24, 1)) - 64'd1) << start;
            end
         end
         default: v = ($urandom_range(1) != 0) ? '1 : '0;
      endcase
      return v;
   endfunction

   // Mostly fitting widths, small ones favored, now and then anything
   function automatic logic [WIDTH_W-1:0] pick_width(int act);
      int lim;
      int r;
      lim = (act < 1) ? 1 : ((act > MAX_SLOTS) ? MAX_SLOTS : act);
      r = $urandom_range(19);
      if (r < 2)
         return WIDTH_W'($urandom_range(127, 0));
      else if (r < 12)
         return WIDTH_W'($urandom_range((lim < 8) ? lim : 8, 1));
      else
         return WIDTH_W'($urandom_range(lim, 1));
   endfunction

   task automatic run_items(int count);
      repeat (count)
         send_request(pick_free_slots(), pick_width(int'(sb.active_slots)),
                      HOP_W'($urandom_range(255)));
      req_valid = 1'b0;
   endtask

   initial begin
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: reset settings
      send_request('1, 7'd1, 8'd0);
      send_request('1, 7'd64, 8'd255);
      send_request('1, 7'd63, 8'd1);
      send_request('0, 7'd1, 8'd3);
      send_request('1, 7'd0, 8'd5);
      send_request('1, 7'd65, 8'd5);
      send_request('1, 7'd127, 8'd200);
      send_request(64'h8000_0000_0000_0000, 7'd1, 8'd255);
      send_request(64'h0000_0000_0000_0001, 7'd1, 8'd1);
      send_request(64'h5555_5555_5555_5555, 7'd1, 8'd7);
      send_request(64'hAAAA_AAAA_AAAA_AAAA, 7'd2, 8'd7);
      send_request(64'h0000_0000_FFFF_FFFF, 7'd32, 8'd128);
      send_request(64'hFFFF_FFFF_0000_0000, 7'd33, 8'd64);
      send_request(64'hF0F0_F0F0_0F0F_0F0F, 7'd4, 8'd2);
      send_request(64'h7FFF_FFFF_FFFF_FFFE, 7'd62, 8'd255);
      req_valid = 1'b0;

      // Settings sweep: full range, extremes, saturation cases
      drain();
      configure(25'd64, 25'd0);
      send_request('1, 7'd1, 8'd255);
      send_request('1, 7'd2, 8'd255);
      req_valid = 1'b0;
      run_items(90);
      drain();
      configure(25'd1, 25'd16777216);
      send_request(64'h0000_0000_0000_0001, 7'd1, 8'd255);
      send_request('1, 7'd2, 8'd9);
      req_valid = 1'b0;
      run_items(60);
      drain();
      configure(25'd0, 25'd12345);
      run_items(30);
      drain();
      configure(25'h1FF_FFFF, 25'h1FF_FFFF);
      run_items(90);
      drain();
      configure(25'd37, 25'($urandom_range(16777216)));
      send_request('1, 7'd37, 8'd4);
      send_request('1, 7'd38, 8'd4);
      req_valid = 1'b0;
      run_items(90);
      drain();
      configure(25'($urandom_range(64, 1)), 25'($urandom));
      run_items(90);
      drain();
      configure(25'($urandom_range(64, 2)), WEIGHT_RESET);
      run_items(60);

      // Last stretch runs back to back with no stalls
      drain();
      calm = 1'b1;
      // let a pending result-side burst run out first
      wait (!rsp_stall);
      run_items(90);
      drain();
      repeat (2 * PIPE_LATENCY) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
